>>> hw/rtl/gbla_pkg.sv
// ----------------------------------------------------------------------------
// gbla_pkg: shared types and constants for the group-by aggregator
// Holds the sequencer state type, divider request and status types, action codes and fixed field widths.
// ----------------------------------------------------------------------------
package gbla_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned CAT_W   = 8;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TIME_W  = 31;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned DIV_W   = 64;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_FL_RD,
    ST_FL_LOAD,
    ST_FL_DIV,
    ST_FL_EMIT
  } state_t;

  // Request into the divider
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  // Status back from the divider
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TIME_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> hw/rtl/gbla_div.sv
// ----------------------------------------------------------------------------
// gbla_div: radix-2 restoring divider
// One quotient bit per cycle, over all 64 dividend bits. Divisor of zero gives 0.
// ----------------------------------------------------------------------------
module gbla_div (
  input  logic               clk,
  input  logic               rst_n,
  input  gbla_pkg::div_req_t req,
  output gbla_pkg::div_rsp_t rsp
);

  logic [gbla_pkg::SUM_W-1:0] quo_r, quo_nxt;
  logic [gbla_pkg::CNT_W:0]   rem_r, rem_nxt;
  logic [gbla_pkg::CNT_W-1:0] dsr_r, dsr_nxt;
  logic [6:0]                 cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic                       zero_r, zero_nxt;
  logic [gbla_pkg::CNT_W:0]   shl;
  logic [gbla_pkg::CNT_W:0]   diff;

  // Shift one dividend bit into the remainder and try a subtract
  always_comb begin
    shl      = {rem_r[gbla_pkg::CNT_W-1:0], quo_r[gbla_pkg::SUM_W-1]};
    diff     = shl - {1'b0, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      zero_nxt = (req.divisor == '0);
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[gbla_pkg::CNT_W]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[gbla_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shl;
        quo_nxt = {quo_r[gbla_pkg::SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    zero_r <= zero_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = zero_r ? '0 : quo_r[gbla_pkg::TIME_W-1:0];

endmodule

>>> hw/rtl/group_by_latency_aggregator_top.sv
// ----------------------------------------------------------------------------
// group_by_latency_aggregator_top: group-by response-time aggregation table
// Keyed table with count, min, max and average per key, flushed on request.
// ----------------------------------------------------------------------------
// An add walks the stored keys with one shared key comparator, one entry a
// cycle, then the matched entry is read and written back, or a new entry is
// written if the table is not full. A flush emits one entry at a time: read
// from memory, load into the shared bit-serial divider that forms the average,
// then emit. busy drops as the final result appears. Results appear on out_*
// for one cycle with out_valid and cannot be held off.
module group_by_latency_aggregator_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_store_id,
  input  logic [31:0] in_terminal_id,
  input  logic [31:0] in_associate_id,
  input  logic [31:0] in_transaction_id,
  input  logic [7:0]  in_category,
  input  logic [31:0] in_response_time,
  output logic        out_valid,
  output logic [31:0] out_store_id_out,
  output logic [31:0] out_terminal_id_out,
  output logic [31:0] out_associate_id_out,
  output logic [31:0] out_transaction_id_out,
  output logic [7:0]  out_category_out,
  output logic [31:0] out_total_count,
  output logic [30:0] out_resp_min,
  output logic [30:0] out_resp_max,
  output logic [30:0] out_resp_avg,
  output logic [31:0] out_sample_count,
  output logic        out_table_overflowed,
  output logic        out_last
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef struct packed {
    logic [31:0] st;
    logic [31:0] te;
    logic [31:0] as_id;
    logic [31:0] tr;
    logic [7:0]  ca;
  } key_t;

  typedef struct packed {
    logic [31:0] total;
    logic [30:0] tmin;
    logic [30:0] tmax;
    logic [63:0] sum;
    logic [31:0] samples;
  } stat_t;

  key_t  key_mem  [TABLE_DEPTH];
  stat_t stat_mem [TABLE_DEPTH];

  gbla_pkg::state_t state_r, state_nxt;
  key_t             in_key_r, in_key_nxt;
  logic [31:0]      rt_r, rt_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             ovf_r, ovf_nxt;
  logic             newe_r, newe_nxt;
  key_t             key_rd_r;
  stat_t            stat_rd_r;
  stat_t            stat_wr;
  logic             key_we, stat_we, key_re, stat_re;
  logic [IDX_W-1:0] addr;
  logic [IDX_W-1:0] key_raddr;
  gbla_pkg::div_req_t dreq;
  gbla_pkg::div_rsp_t drsp;
  logic             ov_r, ov_nxt;
  logic             ol_r, ol_nxt;
  key_t             ok_r, ok_nxt;
  stat_t            os_r, os_nxt;
  logic             valid_s;
  logic [30:0]      t;

  assign addr      = idx_r[IDX_W-1:0];
  assign key_raddr = idx_nxt[IDX_W-1:0];
  assign t         = rt_r[30:0];

  // Table memories: key read runs one entry ahead, registered read
  always_ff @(posedge clk) begin
    if (key_we) key_mem[addr] <= in_key_r;
    if (key_re) key_rd_r <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (stat_we) stat_mem[addr] <= stat_wr;
    if (stat_re) stat_rd_r <= stat_mem[addr];
  end

  gbla_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Update one entry with the held record
  always_comb begin
    stat_wr = stat_rd_r;
    valid_s = !rt_r[31];
    if (newe_r) begin
      stat_wr = '0;
      stat_wr.total = 32'd1;
    end else if (stat_rd_r.total != 32'hFFFF_FFFF) begin
      stat_wr.total = stat_rd_r.total + 32'd1;
    end
    if (valid_s) begin
      if (newe_r || stat_rd_r.samples == '0) begin
        stat_wr.tmin = t;
        stat_wr.tmax = t;
      end else begin
        if (t < stat_rd_r.tmin) stat_wr.tmin = t;
        if (t > stat_rd_r.tmax) stat_wr.tmax = t;
      end
      if (newe_r) begin
        stat_wr.sum     = {33'd0, t};
        stat_wr.samples = 32'd1;
      end else if (stat_rd_r.samples != 32'hFFFF_FFFF) begin
        stat_wr.sum     = stat_rd_r.sum + {33'd0, t};
        stat_wr.samples = stat_rd_r.samples + 32'd1;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    in_key_nxt = in_key_r;
    rt_nxt     = rt_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    ovf_nxt    = ovf_r;
    newe_nxt   = newe_r;
    key_we     = 1'b0;
    stat_we    = 1'b0;
    key_re     = 1'b0;
    stat_re    = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = stat_rd_r.sum;
    dreq.divisor  = stat_rd_r.samples;
    ov_nxt     = 1'b0;
    ol_nxt     = ol_r;
    ok_nxt     = ok_r;
    os_nxt     = os_r;
    case (state_r)
      gbla_pkg::ST_IDLE: begin
        if (start) begin
          in_key_nxt = '{in_store_id, in_terminal_id, in_associate_id,
                         in_transaction_id, in_category};
          rt_nxt  = in_response_time;
          idx_nxt = '0;
          if (in_action == gbla_pkg::ACT_FLUSH) begin
            if (count_r == '0) begin
              ovf_nxt = 1'b0;
            end else begin
              state_nxt = gbla_pkg::ST_FL_RD;
            end
          end else begin
            state_nxt = gbla_pkg::ST_SRCH_RD;
          end
        end
      end
      // Walk stored keys one per cycle
      gbla_pkg::ST_SRCH_RD: begin
        if (idx_r == count_r) begin
          if (count_r == DEPTH_C) begin
            ovf_nxt   = 1'b1;
            state_nxt = gbla_pkg::ST_IDLE;
          end else begin
            newe_nxt  = 1'b1;
            state_nxt = gbla_pkg::ST_UPD_WR;
          end
        end else begin
          key_re    = 1'b1;
          state_nxt = gbla_pkg::ST_SRCH_CMP;
        end
      end
      gbla_pkg::ST_SRCH_CMP: begin
        if (key_rd_r == in_key_r) begin
          stat_re   = 1'b1;
          newe_nxt  = 1'b0;
          state_nxt = gbla_pkg::ST_UPD_RD;
        end else begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 == count_r) begin
            state_nxt = gbla_pkg::ST_SRCH_RD;
          end else begin
            key_re  = 1'b1;
            idx_nxt = idx_r + 1'b1;
            state_nxt = gbla_pkg::ST_SRCH_CMP;
          end
        end
      end
      gbla_pkg::ST_UPD_RD: begin
        state_nxt = gbla_pkg::ST_UPD_WR;
      end
      // Write back the entry
      gbla_pkg::ST_UPD_WR: begin
        stat_we = 1'b1;
        if (newe_r) begin
          key_we    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        newe_nxt  = 1'b0;
        state_nxt = gbla_pkg::ST_IDLE;
      end
      gbla_pkg::ST_FL_RD: begin
        key_re    = 1'b1;
        stat_re   = 1'b1;
        state_nxt = gbla_pkg::ST_FL_LOAD;
      end
      gbla_pkg::ST_FL_LOAD: begin
        dreq.start = 1'b1;
        ok_nxt     = key_rd_r;
        os_nxt     = stat_rd_r;
        ol_nxt     = (idx_r + 1'b1 == count_r);
        state_nxt  = gbla_pkg::ST_FL_DIV;
      end
      gbla_pkg::ST_FL_DIV: begin
        if (drsp.done) begin
          state_nxt = gbla_pkg::ST_FL_EMIT;
        end
      end
      // Drive one result and advance
      gbla_pkg::ST_FL_EMIT: begin
        ov_nxt  = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (ol_r) begin
          count_nxt = '0;
          state_nxt = gbla_pkg::ST_IDLE;
        end else begin
          state_nxt = gbla_pkg::ST_FL_RD;
        end
      end
      default: state_nxt = gbla_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbla_pkg::ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
      idx_r   <= '0;
      newe_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= (ov_nxt && ol_r) ? 1'b0 : ovf_nxt;
      ov_r    <= ov_nxt;
      idx_r   <= idx_nxt;
      newe_r  <= newe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_key_r <= in_key_nxt;
    rt_r     <= rt_nxt;
    ol_r     <= ol_nxt;
    ok_r     <= ok_nxt;
    os_r     <= os_nxt;
    out_resp_avg <= drsp.done ? drsp.quotient : out_resp_avg;
    out_table_overflowed <= ovf_r;
  end

  assign busy                   = (state_r != gbla_pkg::ST_IDLE);
  assign out_valid              = ov_r;
  assign out_store_id_out       = ok_r.st;
  assign out_terminal_id_out    = ok_r.te;
  assign out_associate_id_out   = ok_r.as_id;
  assign out_transaction_id_out = ok_r.tr;
  assign out_category_out       = ok_r.ca;
  assign out_total_count        = os_r.total;
  assign out_resp_min           = os_r.tmin;
  assign out_resp_max           = os_r.tmax;
  assign out_sample_count       = os_r.samples;
  assign out_last               = ol_r;

endmodule

>>> hw/rtl/gbla_checker.sv
// ----------------------------------------------------------------------------
// gbla_assertions: port-level checks for the aggregator
// Watches the top-level ports and reports handshake and result slips.
// ----------------------------------------------------------------------------
module gbla_assertions (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_action,
  input logic out_valid,
  input logic out_last
);

  // An add transfer makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == gbla_pkg::ACT_ADD)) |=> busy)
    else $error("accepted add did not raise busy");

  // Results only appear while working
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result outside an item");

  // Results never come back to back
  a_valid_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in adjacent cycles");

  // Final result ends the flush
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("busy after the final result");

endmodule

bind group_by_latency_aggregator_top gbla_assertions u_gbla_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_action (in_action),
  .out_valid (out_valid),
  .out_last  (out_last)
);

>>> tb/gbla_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gbla_checker: predictor and scoreboard for the group-by aggregator
// Watches input transfers, keeps its own copy of the aggregation table,
// queues the entries each flush should emit and compares every result
// transfer with the oldest queued entry, field by field.
// ----------------------------------------------------------------------------
module gbla_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_store_id,
  input  logic [31:0] in_terminal_id,
  input  logic [31:0] in_associate_id,
  input  logic [31:0] in_transaction_id,
  input  logic [7:0]  in_category,
  input  logic [31:0] in_response_time,
  input  logic        out_valid,
  input  logic [31:0] out_store_id_out,
  input  logic [31:0] out_terminal_id_out,
  input  logic [31:0] out_associate_id_out,
  input  logic [31:0] out_transaction_id_out,
  input  logic [7:0]  out_category_out,
  input  logic [31:0] out_total_count,
  input  logic [30:0] out_resp_min,
  input  logic [30:0] out_resp_max,
  input  logic [30:0] out_resp_avg,
  input  logic [31:0] out_sample_count,
  input  logic        out_table_overflowed,
  input  logic        out_last,
  output int          fail_count,
  output int          entries_due
);

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [31:0] store_id;
    logic [31:0] terminal_id;
    logic [31:0] associate_id;
    logic [31:0] transaction_id;
    logic [7:0]  category;
    logic [31:0] total;
    logic [30:0] rmin;
    logic [30:0] rmax;
    logic [30:0] ravg;
    logic [31:0] samples;
    logic        ovf;
    logic        last;
  } group_row_t;

  // Model copy of the table
  logic [31:0] t_store [DEPTH];
  logic [31:0] t_term  [DEPTH];
  logic [31:0] t_assoc [DEPTH];
  logic [31:0] t_trans [DEPTH];
  logic [7:0]  t_cat   [DEPTH];
  logic [31:0] t_total [DEPTH];
  logic [30:0] t_min   [DEPTH];
  logic [30:0] t_max   [DEPTH];
  logic [63:0] t_sum   [DEPTH];
  logic [31:0] t_samp  [DEPTH];
  int          n_groups;
  logic        dropped;

  group_row_t flush_rows[$];
  int         mismatches;

  assign fail_count = mismatches;

  // Fold one response sample into an entry
  task automatic fold_sample(int e, logic [30:0] t);
    if (t_samp[e] == 0) begin
      t_min[e] = t;
      t_max[e] = t;
    end else begin
      if (t < t_min[e]) t_min[e] = t;
      if (t > t_max[e]) t_max[e] = t;
    end
    if (t_samp[e] != 32'hFFFF_FFFF) begin
      t_sum[e]  = t_sum[e] + 64'(t);
      t_samp[e] = t_samp[e] + 1;
    end
  endtask

  task automatic add_record();
    int   hit;
    logic ok;
    hit = -1;
    ok  = !in_response_time[31];
    for (int e = 0; e < n_groups; e++) begin
      if (hit < 0 && t_store[e] == in_store_id && t_term[e] == in_terminal_id &&
          t_assoc[e] == in_associate_id && t_trans[e] == in_transaction_id &&
          t_cat[e] == in_category)
        hit = e;
    end
    if (hit >= 0) begin
      if (t_total[hit] != 32'hFFFF_FFFF) t_total[hit] = t_total[hit] + 1;
      if (ok) fold_sample(hit, in_response_time[30:0]);
    end else if (n_groups >= DEPTH) begin
      dropped = 1'b1;
    end else begin
      hit = n_groups;
      t_store[hit] = in_store_id;
      t_term[hit]  = in_terminal_id;
      t_assoc[hit] = in_associate_id;
      t_trans[hit] = in_transaction_id;
      t_cat[hit]   = in_category;
      t_total[hit] = 1;
      t_min[hit]   = '0;
      t_max[hit]   = '0;
      t_sum[hit]   = '0;
      t_samp[hit]  = '0;
      if (ok) fold_sample(hit, in_response_time[30:0]);
      n_groups++;
    end
  endtask

  task automatic flush_table();
    group_row_t r;
    logic [63:0] q;
    for (int e = 0; e < n_groups; e++) begin
      q = (t_samp[e] != 0) ? t_sum[e] / 64'(t_samp[e]) : 64'd0;
      r.store_id       = t_store[e];
      r.terminal_id    = t_term[e];
      r.associate_id   = t_assoc[e];
      r.transaction_id = t_trans[e];
      r.category       = t_cat[e];
      r.total          = t_total[e];
      r.rmin           = t_min[e];
      r.rmax           = t_max[e];
      r.ravg           = q[30:0];
      r.samples        = t_samp[e];
      r.ovf            = dropped;
      r.last           = (e == n_groups - 1);
      flush_rows.push_back(r);
    end
    n_groups = 0;
    dropped  = 1'b0;
  endtask

  // Predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    group_row_t got, want;
    if (!rst_n) begin
      n_groups   = 0;
      dropped    = 1'b0;
      mismatches = 0;
      flush_rows.delete();
    end else begin
      if (out_valid) begin
        got = '{out_store_id_out, out_terminal_id_out, out_associate_id_out,
                out_transaction_id_out, out_category_out, out_total_count,
                out_resp_min, out_resp_max, out_resp_avg, out_sample_count,
                out_table_overflowed, out_last};
        if (flush_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          want = flush_rows.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
          end
        end
      end
      if (start && !busy) begin
        if (in_action == gbla_pkg::ACT_FLUSH) flush_table();
        else add_record();
      end
    end
    entries_due = flush_rows.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the group-by aggregator
// Drives directed then random add and flush commands with random gaps,
// fills the table past its depth once, and reports the checker's result.
// ----------------------------------------------------------------------------
module tb;

  logic        clk, rst_n, start, busy;
  logic        in_action;
  logic [31:0] in_store_id, in_terminal_id, in_associate_id, in_transaction_id;
  logic [7:0]  in_category;
  logic [31:0] in_response_time;
  logic        out_valid;
  logic [31:0] out_store_id_out, out_terminal_id_out, out_associate_id_out;
  logic [31:0] out_transaction_id_out, out_total_count, out_sample_count;
  logic [7:0]  out_category_out;
  logic [30:0] out_resp_min, out_resp_max, out_resp_avg;
  logic        out_table_overflowed, out_last;
  int          fail_count, entries_due;
  int          quiet_cycles;
  logic        gaps_on;
  logic [31:0] key_pool [8][4];
  logic [7:0]  cat_pool [8];

  group_by_latency_aggregator_top u_top (.*);
  gbla_checker u_chk (.*);

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one command and hold it until the transfer
  task automatic issue(logic act, logic [31:0] s, logic [31:0] te, logic [31:0] a,
                       logic [31:0] tr, logic [7:0] c, logic [31:0] rt);
    in_action <= act;
    in_store_id <= s;
    in_terminal_id <= te;
    in_associate_id <= a;
    in_transaction_id <= tr;
    in_category <= c;
    in_response_time <= rt;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (gaps_on && $urandom_range(99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (entries_due != 0 || busy);
  endtask

  function automatic logic [31:0] rand_time();
    case ($urandom_range(5))
      0: rand_time = 32'h8000_0000 | $urandom;
      1: rand_time = $urandom_range(20);
      2: rand_time = 32'h7FFF_FFFF - $urandom_range(20);
      default: rand_time = {1'b0, 31'($urandom)};
    endcase
  endfunction

  task automatic add_pooled(int k);
    issue(gbla_pkg::ACT_ADD, key_pool[k][0], key_pool[k][1], key_pool[k][2],
          key_pool[k][3], cat_pool[k], rand_time());
  endtask

  initial begin
    int k;
    gaps_on = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_action = gbla_pkg::ACT_ADD;
    in_store_id = '0; in_terminal_id = '0; in_associate_id = '0;
    in_transaction_id = '0; in_category = '0; in_response_time = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty flush, extreme keys, first and absent samples
    issue(gbla_pkg::ACT_FLUSH, '0, '0, '0, '0, '0, '0);
    issue(gbla_pkg::ACT_ADD, '0, '0, '0, '0, 8'd0, 32'hFFFF_FFFF);
    issue(gbla_pkg::ACT_ADD, '0, '0, '0, '0, 8'd0, 32'd0);
    issue(gbla_pkg::ACT_ADD, '0, '0, '0, '0, 8'd0, 32'h7FFF_FFFF);
    issue(gbla_pkg::ACT_ADD, '1, '1, '1, '1, 8'hFF, 32'h8000_0000);
    issue(gbla_pkg::ACT_ADD, '1, '1, '1, '1, 8'hFF, 32'h7FFF_FFFF);
    issue(gbla_pkg::ACT_ADD, '1, '1, '1, '1, 8'hFF, 32'd5);
    issue(gbla_pkg::ACT_ADD, '1, '1, '1, '1, 8'hFE, 32'd7);
    issue(gbla_pkg::ACT_ADD, 32'd1, '0, '0, '0, 8'd10, 32'h8000_0000);
    issue(gbla_pkg::ACT_ADD, '0, 32'd1, '0, '0, 8'd11, 32'd3);
    issue(gbla_pkg::ACT_ADD, '0, '0, 32'd1, '0, 8'd12, 32'd4);
    issue(gbla_pkg::ACT_ADD, '0, '0, '0, 32'd1, 8'd13, 32'd9);
    issue(gbla_pkg::ACT_ADD, '0, 32'd1, '0, '0, 8'd11, 32'd1);
    issue(gbla_pkg::ACT_FLUSH, '1, '1, '1, '1, '1, '1);
    drain();

    // Fill past the depth so one flush reports the overflow
    gaps_on = 1'b0;
    for (int i = 0; i < 66; i++)
      issue(gbla_pkg::ACT_ADD, $urandom, $urandom, $urandom, i, 8'($urandom),
            rand_time());
    issue(gbla_pkg::ACT_ADD, $urandom, $urandom, $urandom, 32'd7, 8'($urandom),
          rand_time());
    issue(gbla_pkg::ACT_FLUSH, '0, '0, '0, '0, '0, '0);
    gaps_on = 1'b1;
    drain();

    // Random: repeated keys from a small pool, occasional flushes and noise
    for (int round = 0; round < 4; round++) begin
      for (int p = 0; p < 8; p++) begin
        key_pool[p][0] = $urandom; key_pool[p][1] = $urandom;
        key_pool[p][2] = $urandom; key_pool[p][3] = $urandom;
        cat_pool[p] = 8'($urandom);
      end
      for (int i = 0; i < 8; i++) begin
        k = $urandom_range(9);
        if (k == 9) issue(gbla_pkg::ACT_FLUSH, $urandom, $urandom, $urandom,
                          $urandom, 8'($urandom), $urandom);
        else if (k == 8) issue(gbla_pkg::ACT_ADD, $urandom, $urandom, $urandom,
                               $urandom, 8'($urandom), rand_time());
        else add_pooled(k);
      end
      issue(gbla_pkg::ACT_FLUSH, '0, '0, '0, '0, '0, '0);
      if (round == 1) drain();
    end

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && entries_due == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/gbla_pkg.sv
hw/rtl/gbla_div.sv
hw/rtl/group_by_latency_aggregator_top.sv
hw/rtl/gbla_checker.sv
tb/gbla_checker.sv
tb/tb.sv
